[sv/sparse_feature_stream_decoder_macros.svh]
// Assertion macros for the sparse feature stream decoder checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SPARSE_FEATURE_STREAM_DECODER_MACROS_SVH
`define SPARSE_FEATURE_STREAM_DECODER_MACROS_SVH

// Check that a condition holds on every rising clock edge.
`define SFSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SFSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sfsd_pkg.sv]
// Shared types and constants of the sparse feature stream decoder.
// No dependencies; every file but the channel interfaces and the macros header imports it.
package sfsd_pkg;

  // Only word bits [33:0] reach the delta and the flags.
  localparam int ACC_W = 34;
  localparam int STEP_W = 3;
  // Saturation point of the group counter; later groups land above bit 33.
  localparam logic [STEP_W-1:0] STEP_MAX = 3'd5;

  localparam logic [31:0] VALUE_POS_ONE   = 32'h3F80_0000;
  localparam logic [31:0] VALUE_NEG_ONE   = 32'hBF80_0000;
  localparam logic [31:0] WEIGHT_MASK_RST = 32'h0003_FFFF;

  localparam logic [1:0] FLOAT_LAST_BYTE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } sfsd_byte_t;

  typedef struct packed {
    logic [31:0] feature_index;
    logic [31:0] feature_value;
    logic        negative_delta;
  } sfsd_result_t;

endpackage

[sv/sfsd_stream_if.sv]
// Valid/ready channel interfaces of the sparse feature stream decoder.
// Standalone; the input channel carries bytes, the output channel results.
interface sfsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface sfsd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] feature_index;
  logic [31:0] feature_value;
  logic        negative_delta;

  modport source (output valid, output feature_index, output feature_value,
                  output negative_delta, input ready);
  modport sink   (input valid, input feature_index, input feature_value,
                  input negative_delta, output ready);
endinterface

[sv/sfsd_parse.sv]
// Varint, float and delta decode with the per-stream state registers.
// Depends on sfsd_pkg; produces at most one result per accepted word.
module sfsd_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  sfsd_pkg::sfsd_byte_t  in_word,
  input  logic [31:0]           weight_mask,
  output logic                  res_valid,
  output sfsd_pkg::sfsd_result_t res
);
  import sfsd_pkg::*;

  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_cur, acc_w, grp;
  logic [STEP_W-1:0] step_r, step_nxt, step_cur;
  logic              rf_r, rf_nxt, rf_cur;
  logic [1:0]        fcnt_r, fcnt_nxt, fcnt_cur;
  logic [31:0]       fbits_r, fbits_nxt, fbits_cur, fbits_sh;
  logic [31:0]       ridx_r, ridx_nxt, ridx_cur;
  logic [31:0]       pidx_r, pidx_nxt;
  logic              pneg_r, pneg_nxt;
  logic [31:0]       d, mag;
  logic              neg, push;

  always_comb begin
    // A block start drops any partial feature and zeroes the index.
    acc_cur   = in_word.block_start ? '0 : acc_r;
    step_cur  = in_word.block_start ? '0 : step_r;
    rf_cur    = in_word.block_start ? 1'b0 : rf_r;
    fcnt_cur  = in_word.block_start ? '0 : fcnt_r;
    fbits_cur = in_word.block_start ? '0 : fbits_r;
    ridx_cur  = in_word.block_start ? '0 : ridx_r;

    acc_nxt   = acc_cur;
    step_nxt  = step_cur;
    rf_nxt    = rf_cur;
    fcnt_nxt  = fcnt_cur;
    fbits_nxt = fbits_cur;
    ridx_nxt  = ridx_cur;
    pidx_nxt  = pidx_r;
    pneg_nxt  = pneg_r;
    push      = 1'b0;
    res       = '0;

    fbits_sh = 32'(in_word.data_byte) << {fcnt_cur, 3'b000};
    case (step_cur)
      3'd0:    grp = ACC_W'(in_word.data_byte[6:0]);
      3'd1:    grp = ACC_W'(in_word.data_byte[6:0]) << 7;
      3'd2:    grp = ACC_W'(in_word.data_byte[6:0]) << 14;
      3'd3:    grp = ACC_W'(in_word.data_byte[6:0]) << 21;
      3'd4:    grp = ACC_W'(in_word.data_byte[6:0]) << 28;
      default: grp = '0;
    endcase
    acc_w = acc_cur | grp;

    // Zigzag decode of the word shifted right by two.
    d   = acc_w[ACC_W-1:2];
    neg = d[0];
    mag = {1'b0, d[31:1]} ^ {32{neg}};

    if (rf_cur) begin
      fbits_nxt = fbits_cur | fbits_sh;
      if (fcnt_cur == FLOAT_LAST_BYTE) begin
        push                = 1'b1;
        res.feature_index   = pidx_r & weight_mask;
        res.feature_value   = fbits_cur | fbits_sh;
        res.negative_delta  = pneg_r;
        rf_nxt              = 1'b0;
        fcnt_nxt            = '0;
        fbits_nxt           = '0;
      end else begin
        fcnt_nxt = fcnt_cur + 2'd1;
      end
    end else if (in_word.data_byte[7]) begin
      acc_nxt  = acc_w;
      step_nxt = (step_cur < STEP_MAX) ? step_cur + 3'd1 : step_cur;
    end else begin
      acc_nxt            = '0;
      step_nxt           = '0;
      ridx_nxt           = ridx_cur + mag;
      res.feature_index  = (ridx_cur + mag) & weight_mask;
      res.negative_delta = neg;
      if (acc_w[0]) begin
        push              = 1'b1;
        res.feature_value = VALUE_NEG_ONE;
      end else if (acc_w[1]) begin
        // Hold index and flag until the fourth float byte arrives.
        pidx_nxt  = ridx_cur + mag;
        pneg_nxt  = neg;
        rf_nxt    = 1'b1;
        fcnt_nxt  = '0;
        fbits_nxt = '0;
      end else begin
        push              = 1'b1;
        res.feature_value = VALUE_POS_ONE;
      end
    end
  end

  assign res_valid = accept & push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      step_r  <= '0;
      rf_r    <= 1'b0;
      fcnt_r  <= '0;
      fbits_r <= '0;
      ridx_r  <= '0;
      pidx_r  <= '0;
      pneg_r  <= 1'b0;
    end else if (accept) begin
      acc_r   <= acc_nxt;
      step_r  <= step_nxt;
      rf_r    <= rf_nxt;
      fcnt_r  <= fcnt_nxt;
      fbits_r <= fbits_nxt;
      ridx_r  <= ridx_nxt;
      pidx_r  <= pidx_nxt;
      pneg_r  <= pneg_nxt;
    end
  end

endmodule

[sv/sfsd_out_buf.sv]
// Two-entry result buffer: an output register plus a skid register.
// Depends on sfsd_pkg and sfsd_out_if; keeps input ready while one result waits.
module sfsd_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sfsd_pkg::sfsd_result_t push_data,
  output logic                   can_accept,
  sfsd_out_if.source             out_ch
);
  import sfsd_pkg::*;

  sfsd_result_t main_r, skid_r;
  logic         main_v_r, skid_v_r;
  logic         pop;

  assign pop        = main_v_r & out_ch.ready;
  assign can_accept = !skid_v_r;

  assign out_ch.valid          = main_v_r;
  assign out_ch.feature_index  = main_r.feature_index;
  assign out_ch.feature_value  = main_r.feature_value;
  assign out_ch.negative_delta = main_r.negative_delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        // Advance the skid word; no push can arrive while skid is full.
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      main_r <= skid_r;
    end else if (push && (pop || !main_v_r)) begin
      main_r <= push_data;
    end
    if (push && main_v_r && !pop) begin
      skid_r <= push_data;
    end
  end

endmodule

[sv/sparse_feature_stream_decoder.sv]
// Channel     | Dir | Payload                                        | Handshake
// in_ch       | in  | data_byte[7:0], block_start                    | valid/ready
// out_ch      | out | feature_index[31:0], feature_value[31:0], neg  | valid/ready
// cfg         | in  | cfg_wdata[31:0] -> weight_mask                 | cfg_we
//
// One byte per cycle while ready; a result shows next cycle unless out_ch stalls.
// All decode state updates in the same cycle the byte is accepted.
// Sync active-low reset clears all but buffer data; weight_mask resets to 0x3FFFF.
// in_ch.ready drops only while both entries of the two-deep result buffer are full.
module sparse_feature_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  sfsd_in_if.sink     in_ch,
  sfsd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import sfsd_pkg::*;

  logic [31:0]  weight_mask_r;
  logic         accept, res_valid, can_accept;
  sfsd_byte_t   in_word;
  sfsd_result_t res;

  assign in_ch.ready         = can_accept;
  assign accept              = in_ch.valid & can_accept;
  assign in_word.data_byte   = in_ch.data_byte;
  assign in_word.block_start = in_ch.block_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_mask_r <= WEIGHT_MASK_RST;
    end else if (cfg_we) begin
      weight_mask_r <= cfg_wdata;
    end
  end

  sfsd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_word     (in_word),
    .weight_mask (weight_mask_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  sfsd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (can_accept),
    .out_ch     (out_ch)
  );

endmodule

[sv/sfsd_checker.sv]
// Port-level checks on the sparse feature stream decoder, bound to the top level.
// Depends on sfsd_pkg and sparse_feature_stream_decoder_macros.svh.
`include "sparse_feature_stream_decoder_macros.svh"

module sfsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_block_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_feature_index,
  input logic [31:0] out_feature_value,
  input logic        out_negative_delta
);
  import sfsd_pkg::*;

  logic in_acc;
  assign in_acc = in_valid & in_ready;

  `SFSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_feature_index) && $stable(out_feature_value) && $stable(out_negative_delta), "stalled result changed")
  `SFSD_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")
  `SFSD_ASSERT_NEXT(a_start_cont_silent, in_acc && in_block_start && in_data_byte[7] && !out_valid, !out_valid, "continuation byte at block start gave a result")
  `SFSD_ASSERT_NEXT(a_start_neg_one, in_acc && in_block_start && !in_data_byte[7] && in_data_byte[0] && !out_valid, out_valid && (out_feature_value == VALUE_NEG_ONE), "one-byte negative feature missing")

endmodule

bind sparse_feature_stream_decoder sfsd_checker u_sfsd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_data_byte       (in_ch.data_byte),
  .in_block_start     (in_ch.block_start),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_feature_index  (out_ch.feature_index),
  .out_feature_value  (out_ch.feature_value),
  .out_negative_delta (out_ch.negative_delta)
);

[tb/sfsd_decode_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the sparse feature stream decoder: tracks the decode state,
// predicts each feature and compares it with the result channel.
// Depends on sfsd_pkg and the channel interfaces in sfsd_stream_if.sv.
module sfsd_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  sfsd_in_if          in_mon,
  sfsd_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          mismatch_count,
  output int          feature_backlog
);
  import sfsd_pkg::*;

  localparam int unsigned WORD_GROUPS = 10;

  logic [31:0]  weight_mask;
  logic [63:0]  varint_acc;
  int unsigned  group_idx;
  logic         float_mode;
  logic [1:0]   float_cnt;
  logic [31:0]  float_acc;
  logic [63:0]  index_acc;
  logic [63:0]  held_index;
  logic         held_neg;

  sfsd_result_t features_due_q[$];
  sfsd_result_t want;
  sfsd_result_t got;
  int           fault_total = 0;

  initial begin
    mismatch_count  = 0;
    feature_backlog = 0;
  end

  function automatic void queue_feature(input logic [63:0] idx, input logic [31:0] value,
                                        input logic neg);
    sfsd_result_t r;
    r.feature_index  = idx[31:0] & weight_mask;
    r.feature_value  = value;
    r.negative_delta = neg;
    features_due_q.push_back(r);
  endfunction

  // Advance the decode state by one accepted word.
  task automatic decode_byte(input logic [7:0] b, input logic block_start);
    int unsigned shift;
    logic [63:0] varint;
    logic [31:0] zz;
    logic [31:0] mag;
    logic        neg;
    logic [63:0] delta;
    if (block_start) begin
      index_acc  = '0;
      varint_acc = '0;
      group_idx  = 0;
      float_mode = 1'b0;
      float_cnt  = '0;
      float_acc  = '0;
    end
    if (float_mode) begin
      float_acc |= {24'd0, b} << (8 * float_cnt);
      if (float_cnt == FLOAT_LAST_BYTE) begin
        queue_feature(held_index, float_acc, held_neg);
        float_mode = 1'b0;
        float_cnt  = '0;
        float_acc  = '0;
      end else begin
        float_cnt = float_cnt + 2'd1;
      end
      return;
    end
    shift = 7 * group_idx;
    // Drop groups that land above bit 63.
    if (shift < 64) varint_acc |= {57'd0, b[6:0]} << shift;
    if (b[7]) begin
      if (group_idx < WORD_GROUPS) group_idx++;
      return;
    end
    varint     = varint_acc;
    varint_acc = '0;
    group_idx  = 0;
    zz    = varint[33:2];
    neg   = zz[0];
    mag   = (zz >> 1) ^ {32{neg}};
    delta = {{32{neg}}, mag};
    index_acc = index_acc + delta;
    if (varint[0]) begin
      queue_feature(index_acc, VALUE_NEG_ONE, neg);
    end else if (varint[1]) begin
      // Hold index and sign until the fourth float byte arrives.
      held_index = index_acc;
      held_neg   = neg;
      float_mode = 1'b1;
      float_cnt  = '0;
      float_acc  = '0;
    end else begin
      queue_feature(index_acc, VALUE_POS_ONE, neg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      weight_mask = WEIGHT_MASK_RST;
      varint_acc  = '0;
      group_idx   = 0;
      float_mode  = 1'b0;
      float_cnt   = '0;
      float_acc   = '0;
      index_acc   = '0;
      held_index  = '0;
      held_neg    = 1'b0;
      features_due_q.delete();
    end else begin
      if (cfg_we) weight_mask = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        got.feature_index  = out_mon.feature_index;
        got.feature_value  = out_mon.feature_value;
        got.negative_delta = out_mon.negative_delta;
        if (features_due_q.size() == 0) begin
          fault_total++;
          if (fault_total <= 10)
            $display("unexpected feature: index %h value %h neg %b",
                     got.feature_index, got.feature_value, got.negative_delta);
        end else begin
          want = features_due_q.pop_front();
          if (got.feature_index !== want.feature_index ||
              got.feature_value !== want.feature_value ||
              got.negative_delta !== want.negative_delta) begin
            fault_total++;
            if (fault_total <= 10)
              $display("feature mismatch: expected index %h value %h neg %b, got %h %h %b",
                       want.feature_index, want.feature_value, want.negative_delta,
                       got.feature_index, got.feature_value, got.negative_delta);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.data_byte, in_mon.block_start);
    end
    mismatch_count  <= fault_total;
    feature_backlog <= features_due_q.size();
  end

endmodule

[tb/sparse_feature_stream_decoder_test.sv]
`timescale 1ns / 100ps
// Top of the sparse feature stream decoder testbench: clock, reset, stimulus
// and verdict. Depends on sfsd_pkg, sfsd_stream_if.sv and sfsd_decode_checker.
module sparse_feature_stream_decoder_test;
  import sfsd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 110;
  localparam int PHASES      = 7;
  localparam int WORD_GROUPS = 10;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKE} rx_mode_e;
  typedef enum logic [1:0] {FEAT_POS, FEAT_NEG, FEAT_FLOAT} feat_kind_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          mismatch_count;
  int          feature_backlog;
  int          cycle_count = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  logic [3:0]  rx_tick = '0;
  int          burst_left = 0;
  int          gap_max = 0;
  sfsd_byte_t  stream_q[$];

  sfsd_in_if  in_ch();
  sfsd_out_if out_ch();

  sparse_feature_stream_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sfsd_decode_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .feature_backlog (feature_backlog)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result sink backpressure.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 4'd1;
    case (rx_mode)
      RX_OPEN:     out_ch.ready <= 1'b1;
      RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_ch.ready <= (rx_tick < 4'd11);
      default:     out_ch.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic logic [31:0] zigzag(input logic [31:0] d);
    return {d[30:0], 1'b0} ^ {32{d[31]}};
  endfunction

  // Encode one feature as varint groups plus optional float bytes.
  task automatic add_feature(input feat_kind_e kind, input logic [31:0] delta,
                             input logic [31:0] fbits, input logic first_in_block,
                             input int extra_groups, input logic junk_high);
    logic [63:0] varint;
    int          groups;
    logic [7:0]  b;
    logic        start;
    varint = {30'd0, zigzag(delta), 2'b00};
    if (kind == FEAT_NEG) begin
      varint[0] = 1'b1;
      varint[1] = 1'($urandom_range(0, 1));
    end else if (kind == FEAT_FLOAT) begin
      varint[1] = 1'b1;
    end
    if (junk_high) varint[63:34] = 30'($urandom);
    groups = 1;
    while (groups < WORD_GROUPS && (varint >> (7 * groups)) != 64'd0) groups++;
    groups = groups + extra_groups;
    start = first_in_block;
    for (int k = 0; k < groups; k++) begin
      if (k < WORD_GROUPS) b[6:0] = 7'(varint >> (7 * k));
      else b[6:0] = 7'($urandom);
      // Upper bits of the last kept group fall off the 64-bit varint.
      if (k == WORD_GROUPS - 1) b[6:1] = 6'($urandom);
      b[7] = (k != groups - 1);
      stream_q.push_back('{b, start});
      start = 1'b0;
    end
    if (kind == FEAT_FLOAT)
      for (int i = 0; i < 4; i++) stream_q.push_back('{fbits[8 * i +: 8], 1'b0});
  endtask

  task automatic send_byte(input sfsd_byte_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= item.data_byte;
    in_ch.block_start <= item.block_start;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  initial begin
    int          pick;
    feat_kind_e  kind;
    logic [31:0] delta;
    logic [31:0] mask_value;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.block_start = 1'b0;
    out_ch.ready      = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1:       mask_value = 32'hFFFF_FFFF;
          2:       mask_value = 32'h0000_0000;
          4:       mask_value = 32'h0000_0001;
          6:       mask_value = WEIGHT_MASK_RST;
          default: mask_value = $urandom;
        endcase
        cfg_we    <= 1'b1;
        cfg_wdata <= mask_value;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      rx_mode <= rx_mode_e'(phase % 4);
      gap_max = (phase * 5) % 9;

      if (phase == 0) begin
        add_feature(FEAT_POS, 32'd0, 32'd0, 1'b1, 0, 1'b0);
        add_feature(FEAT_NEG, 32'd5, 32'd0, 1'b0, 0, 1'b0);
        add_feature(FEAT_FLOAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
        add_feature(FEAT_POS, 32'h7FFF_FFFF, 32'd0, 1'b0, 0, 1'b0);
        // Overlong varint with junk above bit 33 and a saturated group count.
        add_feature(FEAT_NEG, 32'h8000_0000, 32'd0, 1'b0, 1, 1'b1);
        // After a float feature and a stray two-byte feature, restart the block halfway through a varint.
        add_feature(FEAT_FLOAT, 32'd1, 32'd0, 1'b0, 0, 1'b0);
        stream_q.push_back('{8'hA5, 1'b0});
        stream_q.push_back('{8'h5A, 1'b0});
        stream_q.push_back('{8'hFF, 1'b1});
        add_feature(FEAT_POS, 32'hFFFF_FFFE, 32'd0, 1'b1, 0, 1'b0);
      end else begin
        while (stream_q.size() < PHASE_BYTES) begin
          pick = $urandom_range(0, 99);
          if (pick < 6) begin
            stream_q.push_back('{8'($urandom), ($urandom_range(0, 7) == 0)});
          end else begin
            kind = feat_kind_e'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
              0:       delta = 32'd0 - $urandom_range(1, 1000);
              1:       delta = $urandom;
              2:       delta = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
              default: delta = $urandom_range(0, 300);
            endcase
            add_feature(kind, delta, $urandom, pick < 14,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0,
                        $urandom_range(0, 9) == 0);
          end
        end
      end

      while (stream_q.size() > 0) send_byte(stream_q.pop_front());
      in_ch.valid <= 1'b0;
      burst_left = 0;
      // Drain, then let the pipeline settle before the next mask write.
      do @(posedge clk); while (feature_backlog != 0);
      repeat (4) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && feature_backlog == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
